FILE: rtl/hcfp_pkg.sv
// Package for the hex channel frame parser: widths, ASCII codes, control
// types for the top level and the byte classification functions for the control.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hcfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int NIB_W     = 4;
    localparam int NUM_CELLS = 8;
    localparam int VALUE_W   = NIB_W * NUM_CELLS;
    localparam int CHAN_W    = 7;
    localparam int CNT_W     = $clog2(NUM_CELLS);

    localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(NUM_CELLS - 1);

    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_UP_G  = 8'h47;
    localparam logic [BYTE_W-1:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LO_G  = 8'h67;
    localparam logic [BYTE_W-1:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UP_F  = 8'h46;
    localparam logic [NIB_W-1:0]  HEX_A_VALUE = 4'd10;

    typedef enum logic
    {
        ST_IDLE,
        ST_FRAME
    } state_t;

    typedef struct packed
    {
        logic ok;
        logic [NIB_W-1:0] nib;
    } digit_t;

    // Control handed to every cell in the value chain
    typedef struct packed
    {
        logic clear;
        logic shift;
        logic [NIB_W-1:0] nib;
    } cell_ctl_t;

    // Status from the frame control to the top level
    typedef struct packed
    {
        logic emit;
        logic can_emit;
        logic [CHAN_W-1:0] channel;
    } ctrl_status_t;

    function automatic logic is_channel_letter(input logic [BYTE_W-1:0] b);
        return ((b >= CHAR_UP_G) && (b <= CHAR_UP_Z)) || ((b >= CHAR_LO_G) && (b <= CHAR_LO_Z));
    endfunction

    function automatic logic is_lower_channel(input logic [BYTE_W-1:0] b);
        return (b >= CHAR_LO_G) && (b <= CHAR_LO_Z);
    endfunction

    function automatic logic is_early_end(input logic [BYTE_W-1:0] b);
        return (b == CHAR_CR) || (b == CHAR_LF) || (b == CHAR_PLUS);
    endfunction

    function automatic digit_t nibble_of(input logic [BYTE_W-1:0] b);
        digit_t d;
        d.ok  = 1'b0;
        d.nib = '0;
        if ((b >= CHAR_0) && (b <= CHAR_9))
        begin
            d.ok  = 1'b1;
            d.nib = b[NIB_W-1:0] - CHAR_0[NIB_W-1:0];
        end
        else if ((b >= CHAR_UP_A) && (b <= CHAR_UP_F))
        begin
            d.ok  = 1'b1;
            d.nib = b[NIB_W-1:0] - CHAR_UP_A[NIB_W-1:0] + HEX_A_VALUE;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hcfp_if.sv
// Handshake channels of the hex channel frame parser: received bytes in,
// completed frames out. Depends on hcfp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hcfp_byte_if;
    logic valid;
    logic ready;
    logic [hcfp_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hcfp_frame_if;
    logic valid;
    logic ready;
    logic [hcfp_pkg::CHAN_W-1:0]  channel;
    logic [hcfp_pkg::VALUE_W-1:0] frame_value;

    modport source (output valid, output channel, output frame_value, input ready);
    modport sink   (input valid, input channel, input frame_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/hcfp_nibble_cell.sv
// One cell of the value chain: holds a hex digit and passes it to the
// next cell when a digit shifts in. Depends on hcfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcfp_nibble_cell
(
    input  wire logic                      clk,
    input  wire hcfp_pkg::cell_ctl_t       ctl,
    input  wire logic [hcfp_pkg::NIB_W-1:0] nib_in,
    output logic      [hcfp_pkg::NIB_W-1:0] nib_out,
    output logic      [hcfp_pkg::NIB_W-1:0] nib_next
);
    import hcfp_pkg::*;

    logic [NIB_W-1:0] nib_reg;

    always_comb
    begin
        if (ctl.clear)
        begin
            nib_next = '0;
        end
        else if (ctl.shift)
        begin
            nib_next = nib_in;
        end
        else
        begin
            nib_next = nib_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nib_reg <= nib_next;
    end

    assign nib_out = nib_reg;

endmodule

`default_nettype wire

FILE: rtl/hcfp_ctrl.sv
// Frame control: classifies each accepted byte, tracks the frame state,
// digit count and channel letter, and drives the value chain. Depends on hcfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcfp_ctrl
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [hcfp_pkg::BYTE_W-1:0] rx_byte,
    output hcfp_pkg::cell_ctl_t              cell_ctl,
    output hcfp_pkg::ctrl_status_t           status
);
    import hcfp_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CHAN_W-1:0] channel_reg;
    logic [CHAN_W-1:0] channel_next;

    digit_t digit;
    logic   letter;
    logic   lower;
    logic   early;
    logic   last;

    always_comb
    begin
        digit  = nibble_of(rx_byte);
        letter = is_channel_letter(rx_byte);
        lower  = is_lower_channel({1'b0, channel_reg});
        early  = is_early_end(rx_byte);
        last   = (count_reg == LAST_DIGIT);
    end

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        channel_next = channel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && letter)
                begin
                    state_next   = ST_FRAME;
                    count_next   = '0;
                    channel_next = rx_byte[CHAN_W-1:0];
                end
            end
            ST_FRAME:
            begin
                if (accept)
                begin
                    if (digit.ok && !last)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        // full frame, early end or bad byte: back to idle
                        state_next = ST_IDLE;
                        count_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                count_next = '0;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cell_ctl.clear  = 1'b0;
        cell_ctl.shift  = 1'b0;
        cell_ctl.nib    = digit.nib;
        status.emit     = 1'b0;
        status.can_emit = 1'b0;
        status.channel  = channel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cell_ctl.clear = accept && letter;
            end
            ST_FRAME:
            begin
                cell_ctl.shift  = accept && digit.ok;
                status.emit     = accept && ((digit.ok && last) || (!digit.ok && lower && early));
                status.can_emit = lower || last;
            end
            default:
            begin
                cell_ctl.clear = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        channel_reg <= channel_next;
    end

endmodule

`default_nettype wire

FILE: rtl/hex_channel_frame_parser.sv
// Top level of the hex channel frame parser: frame control, a chain of eight
// digit cells and the output register. Depends on hcfp_pkg, hcfp_if,
// hcfp_ctrl and hcfp_nibble_cell.
`timescale 1ns / 1ps
`default_nettype none

// Parses received ASCII bytes into channel frames. A letter G-Z or g-z opens a
// frame; each uppercase hex digit shifts into a chain of eight 4-bit cells, and
// the eighth digit delivers the channel letter and the 32-bit value. A
// lowercase frame also closes on CR, LF or '+', with the digits so far
// right-aligned. Any other byte drops the frame without a result. One byte is
// taken per clock cycle; a frame shows on the output the cycle after its last
// byte is accepted. The single output register lets bytes keep flowing while a
// frame waits to be taken, and input stalls only when a waiting frame is
// unread and the next byte could close another one. There is no startup delay
// after reset.
module hex_channel_frame_parser
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hcfp_byte_if.sink   rx,
    hcfp_frame_if.source frame
);
    import hcfp_pkg::*;

    cell_ctl_t    cell_ctl;
    ctrl_status_t status;
    logic         accept;

    logic [NIB_W-1:0] nib_q [NUM_CELLS];
    logic [NIB_W-1:0] nib_d [NUM_CELLS];
    logic [VALUE_W-1:0] value_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CHAN_W-1:0]  out_channel_reg;
    logic [VALUE_W-1:0] out_value_reg;

    assign rx.ready = !out_valid_reg || frame.ready || !status.can_emit;
    assign accept   = rx.valid && rx.ready;

    hcfp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx.rx_byte),
        .cell_ctl (cell_ctl),
        .status   (status)
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        logic [NIB_W-1:0] nib_in;
        if (i == 0)
        begin : g_head
            assign nib_in = cell_ctl.nib;
        end
        else
        begin : g_body
            assign nib_in = nib_q[i-1];
        end

        hcfp_nibble_cell u_cell
        (
            .clk      (clk),
            .ctl      (cell_ctl),
            .nib_in   (nib_in),
            .nib_out  (nib_q[i]),
            .nib_next (nib_d[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            value_next[i*NIB_W +: NIB_W] = nib_d[i];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (status.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the frame until taken
    always_ff @(posedge clk)
    begin
        if (status.emit)
        begin
            out_channel_reg <= status.channel;
            out_value_reg   <= value_next;
        end
    end

    assign frame.valid       = out_valid_reg;
    assign frame.channel     = out_channel_reg;
    assign frame.frame_value = out_value_reg;

endmodule

`default_nettype wire

FILE: tb/sv/hex_channel_frame_parser_tb.sv
// Testbench for hex_channel_frame_parser. It drives received bytes, predicts the
// completed frames and checks each one as it is taken from the output channel.
// Depends on hcfp_pkg, hcfp_if and the parser RTL.
`timescale 1ns / 1ps

module hex_channel_frame_parser_tb;

    import hcfp_pkg::*;

    typedef struct
    {
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] value;
    } frame_t;

    logic clk;
    logic rst_n;

    hcfp_byte_if  rx_if ();
    hcfp_frame_if frame_if ();

    hex_channel_frame_parser DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .frame (frame_if)
    );

    logic [BYTE_W-1:0] byte_queue[$];
    frame_t            frames_due[$];

    // Parser state as predicted
    logic               in_frame;
    logic [3:0]         digit_count;
    logic [BYTE_W-1:0]  held_channel;
    logic [VALUE_W-1:0] value_acc;

    int  accepted_count = 0;
    int  stim_total = 0;
    int  failures = 0;
    bit  byte_taken = 0;
    bit  hold_off = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #1ms;
        $display("hex_channel_frame_parser_tb: FAIL");
        $finish;
    end

    function automatic int idle_pct(input bit sender);
        int phase;
        phase = (stim_total == 0) ? 0 : (accepted_count * 3) / stim_total;
        if (phase == 0)
            return sender ? 34 : 51;
        else if (phase == 1)
            return sender ? 51 : 34;
        return 0;
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(input int v);
        if (v < 10)
            return CHAR_0 + BYTE_W'(v);
        return CHAR_UP_A + BYTE_W'(v - 10);
    endfunction

    function automatic logic [BYTE_W-1:0] early_end_char();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0)
            return CHAR_CR;
        else if (pick == 1)
            return CHAR_LF;
        return CHAR_PLUS;
    endfunction

    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        logic       is_digit;
        logic [3:0] nib;
        logic       closes;
        frame_t     f;
        is_digit = 1'b0;
        nib      = '0;
        closes   = 1'b0;
        if (!in_frame)
        begin
            if (((b >= CHAR_UP_G) && (b <= CHAR_UP_Z)) || ((b >= CHAR_LO_G) && (b <= CHAR_LO_Z)))
            begin
                in_frame     = 1'b1;
                digit_count  = '0;
                held_channel = b;
                value_acc    = '0;
            end
        end
        else
        begin
            if ((b >= CHAR_0) && (b <= CHAR_9))
            begin
                is_digit = 1'b1;
                nib      = 4'(b - CHAR_0);
            end
            else if ((b >= CHAR_UP_A) && (b <= CHAR_UP_F))
            begin
                is_digit = 1'b1;
                nib      = 4'(b - CHAR_UP_A + 8'd10);
            end
            if (is_digit)
            begin
                value_acc   = {value_acc[VALUE_W-5:0], nib};
                digit_count = digit_count + 4'd1;
                closes      = (digit_count >= 4'd8);
            end
            else if ((held_channel >= CHAR_LO_G) && (held_channel <= CHAR_LO_Z)
                     && ((b == CHAR_CR) || (b == CHAR_LF) || (b == CHAR_PLUS)))
                closes = 1'b1;
            else
            begin
                // drop the frame; this byte is not a new start
                in_frame    = 1'b0;
                digit_count = '0;
            end
            if (closes)
            begin
                f.channel = held_channel[CHAN_W-1:0];
                f.value   = value_acc;
                frames_due.push_back(f);
                in_frame    = 1'b0;
                digit_count = '0;
            end
        end
    endtask

    // Sample both channels: check the outgoing frame first, then predict
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_if.valid && frame_if.ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("unexpected frame: channel %h value %h",
                           frame_if.channel, frame_if.frame_value);
                    failures++;
                end
                else
                begin
                    if (frame_if.channel !== frames_due[0].channel)
                    begin
                        $error("channel: expected %h, got %h",
                               frames_due[0].channel, frame_if.channel);
                        failures++;
                    end
                    if (frame_if.frame_value !== frames_due[0].value)
                    begin
                        $error("frame_value: expected %h, got %h",
                               frames_due[0].value, frame_if.frame_value);
                        failures++;
                    end
                    void'(frames_due.pop_front());
                end
            end
            if (rx_if.valid && rx_if.ready)
            begin
                parse_byte(rx_if.rx_byte);
                byte_taken = 1'b1;
                accepted_count++;
            end
        end
    end

    // Byte driver: hold an offered item until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            rx_if.valid <= 1'b0;
        else if (byte_taken || !rx_if.valid)
        begin
            if (byte_taken)
                void'(byte_queue.pop_front());
            byte_taken = 1'b0;
            if ((byte_queue.size() > 0) && ($urandom_range(0, 99) >= idle_pct(1'b1)))
            begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= byte_queue[0];
            end
            else
                rx_if.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            frame_if.ready <= 1'b0;
        else
            frame_if.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end

    // Long receiver hold-off late in the run so the parser backs up
    initial
    begin
        wait ((stim_total != 0) && (accepted_count >= (stim_total * 3) / 4));
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
    end

    task automatic push_string(input string s);
        foreach (s[i])
            byte_queue.push_back(s[i]);
    endtask

    initial
    begin
        logic [BYTE_W-1:0] frame_bytes[$];
        int frame_count;
        int n_digits;
        int pos;
        bit lower;

        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        frame_if.ready = 1'b0;
        in_frame       = 1'b0;
        digit_count    = '0;
        held_channel   = '0;
        value_acc      = '0;

        // Directed: all-zero and all-one bytes while idle, full uppercase frame
        // of F digits, lowercase closes with and without digits, uppercase frame
        // hit by LF, lowercase hex digit, letter inside a frame
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        push_string("ZFFFFFFFF");
        byte_queue.push_back(CHAR_LO_G);
        byte_queue.push_back(CHAR_CR);
        push_string("z1+");
        push_string("G0");
        byte_queue.push_back(CHAR_LF);
        push_string("ha");
        push_string("mH5");

        frame_count = 0;
        while (frame_count < 600)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                repeat ($urandom_range(1, 3))
                    byte_queue.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                frame_bytes.delete();
                lower = $urandom_range(0, 1);
                if (lower)
                    frame_bytes.push_back(BYTE_W'($urandom_range(CHAR_LO_G, CHAR_LO_Z)));
                else
                    frame_bytes.push_back(BYTE_W'($urandom_range(CHAR_UP_G, CHAR_UP_Z)));
                n_digits = lower ? $urandom_range(0, 8) : 8;
                repeat (n_digits)
                    frame_bytes.push_back(hex_char($urandom_range(0, 15)));
                if (lower && (n_digits < 8))
                    frame_bytes.push_back(early_end_char());
                // corrupt some frames past the channel letter
                if ($urandom_range(0, 99) < 15)
                begin
                    pos = $urandom_range(1, frame_bytes.size() - 1);
                    case ($urandom_range(0, 2))
                        0: frame_bytes[pos] = BYTE_W'($urandom_range(0, 255));
                        1: frame_bytes[pos] = early_end_char();
                        default: frame_bytes[pos] = BYTE_W'($urandom_range(8'h61, 8'h66));
                    endcase
                end
                foreach (frame_bytes[i])
                    byte_queue.push_back(frame_bytes[i]);
                frame_count += frame_bytes.size();
            end
        end
        stim_total = byte_queue.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while ((byte_queue.size() != 0) || (frames_due.size() != 0))
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (failures == 0)
            $display("hex_channel_frame_parser_tb: PASS");
        else
            $display("hex_channel_frame_parser_tb: FAIL");
        $finish;
    end

endmodule
